@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/utf8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Types and byte classification constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;

    localparam logic [LEN_W-1:0] LEN_IDLE  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
    localparam logic [1:0]        CONT_TAG   = 2'b10;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } beat_t;

    typedef struct packed {
        logic              valid;
        logic [CP_W-1:0]   code_point;
        logic [LEN_W-1:0]  seq_length;
        logic              error;
    } result_t;

endpackage

@@ rtl/core/utf8sd_in_stage.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder input stage
// Registers one incoming byte beat and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
module utf8sd_in_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               in_byte,
    input  logic                     advance,
    output utf8sd_pkg::beat_t        beat
);
    import utf8sd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    assign in_stall = valid_reg && !advance;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
            data_next  = in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

@@ rtl/core/utf8sd_decode.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder core
// Sequence state, per-byte decode and overlong check, and the result register.
// ----------------------------------------------------------------------------
module utf8sd_decode (
    input  logic                     clk,
    input  logic                     rst_n,
    input  utf8sd_pkg::beat_t        beat,
    input  logic                     out_stall,
    output logic                     advance,
    output utf8sd_pkg::result_t      result
);
    import utf8sd_pkg::*;

    logic [LEN_W-1:0]  exp_reg,     exp_next;
    logic [LEN_W-1:0]  held_reg,    held_next;
    logic [CP_W-1:0]   partial_reg, partial_next;
    logic [2:0]        lead_reg,    lead_next;
    logic [BYTE_W-1:0] second_reg,  second_next;
    logic              bad_reg,     bad_next;

    logic              out_valid_reg, out_valid_next;
    logic [CP_W-1:0]   cp_reg,  cp_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              err_reg, err_next;

    logic [BYTE_W-1:0] b;
    logic              emit;
    logic              start;
    logic              bad_n;
    logic [BYTE_W-1:0] second_n;
    logic [CP_W-1:0]   partial_n;
    logic [LEN_W-1:0]  held_n;
    logic              overlong;
    logic [CP_W-1:0]   res_cp;
    logic [LEN_W-1:0]  res_len;
    logic              res_err;

    assign advance = !out_valid_reg || !out_stall;
    assign b       = beat.data;

    always_comb
    begin
        exp_next     = exp_reg;
        held_next    = held_reg;
        partial_next = partial_reg;
        lead_next    = lead_reg;
        second_next  = second_reg;
        bad_next     = bad_reg;
        emit         = 1'b0;
        start        = 1'b0;
        res_cp       = '0;
        res_len      = LEN_IDLE;
        res_err      = 1'b0;
        bad_n        = bad_reg | (b[7:6] != CONT_TAG);
        second_n     = (held_reg == LEN_ONE) ? b : second_reg;
        partial_n    = {partial_reg[CP_W-7:0], b[5:0]};
        held_n       = held_reg + LEN_ONE;
        case (exp_reg)
            LEN_TWO:   overlong = (partial_n[10:7] == 4'd0);
            LEN_THREE: overlong = (partial_n[CP_W-1:12] == '0) && !second_n[5];
            default:   overlong = (lead_reg == 3'd0) && (second_n[5:4] == 2'd0);
        endcase

        if (beat.valid && advance)
        begin
            if (exp_reg == LEN_IDLE)
            begin
                if (!b[7])
                begin
                    emit    = 1'b1;
                    res_cp  = {{(CP_W-BYTE_W){1'b0}}, b};
                    res_len = LEN_ONE;
                end
                else if ((b & LEAD2_MASK) == LEAD2_CODE)
                begin
                    start        = 1'b1;
                    exp_next     = LEN_TWO;
                    partial_next = {{(CP_W-5){1'b0}}, b[4:0]};
                end
                else if ((b & LEAD3_MASK) == LEAD3_CODE)
                begin
                    start        = 1'b1;
                    exp_next     = LEN_THREE;
                    partial_next = {{(CP_W-4){1'b0}}, b[3:0]};
                end
                else if ((b & LEAD4_MASK) == LEAD4_CODE)
                begin
                    start        = 1'b1;
                    exp_next     = LEN_FOUR;
                    partial_next = {{(CP_W-3){1'b0}}, b[2:0]};
                end
                else
                begin
                    emit    = 1'b1;
                    res_err = 1'b1;
                end
                if (start)
                begin
                    held_next   = LEN_ONE;
                    lead_next   = b[2:0];
                    second_next = '0;
                    bad_next    = 1'b0;
                end
            end
            else if (held_n < exp_reg)
            begin
                held_next    = held_n;
                partial_next = partial_n;
                second_next  = second_n;
                bad_next     = bad_n;
            end
            else
            begin
                emit = 1'b1;
                if (bad_n || overlong)
                begin
                    res_err = 1'b1;
                end
                else
                begin
                    res_cp  = partial_n;
                    res_len = exp_reg;
                end
                exp_next     = LEN_IDLE;
                held_next    = LEN_IDLE;
                partial_next = '0;
                lead_next    = 3'd0;
                second_next  = '0;
                bad_next     = 1'b0;
            end
        end

        out_valid_next = advance ? emit : out_valid_reg;
        cp_next        = emit ? res_cp  : cp_reg;
        len_next       = emit ? res_len : len_reg;
        err_next       = emit ? res_err : err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg       <= LEN_IDLE;
            held_reg      <= LEN_IDLE;
            partial_reg   <= '0;
            lead_reg      <= 3'd0;
            second_reg    <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            exp_reg       <= exp_next;
            held_reg      <= held_next;
            partial_reg   <= partial_next;
            lead_reg      <= lead_next;
            second_reg    <= second_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg  <= cp_next;
        len_reg <= len_next;
        err_reg <= err_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.code_point = cp_reg;
    assign result.seq_length = len_reg;
    assign result.error      = err_reg;

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Byte-serial UTF-8 decoder with valid/stall channels on both sides.
// ----------------------------------------------------------------------------
// The input channel carries one raw byte per beat on in_byte. The output
// channel carries one result beat per completed sequence: code_point,
// seq_length and error, where an error beat has zero code point and length.
// Single-byte characters and bad lead bytes give a result at once; the other
// bytes of a multi-byte sequence give no beat until its last byte arrives.
// A byte is registered in the input register on acceptance and decoded once
// the decoder takes it, and its result beat is held in the result register.
// One byte is taken every cycle while the receiver does not stall; the rate
// is set by the single decode step between the input and result registers.
// While the receiver stalls, the result register holds its beat and one more
// byte may still be taken into the input register; after that in_stall rises
// until the result is taken.
// Reset clears both registers' valid flags and returns the decoder to idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_point,
    output logic [2:0]  seq_length,
    output logic        error
);
    import utf8sd_pkg::*;

    beat_t   beat;
    result_t result;
    logic    advance;
    logic    err_clean;
    logic    len_legal;
    logic    ascii_beat;

    utf8sd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .advance  (advance),
        .beat     (beat)
    );

    utf8sd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .out_stall (out_stall),
        .advance   (advance),
        .result    (result)
    );

    assign out_valid  = result.valid;
    assign code_point = result.code_point;
    assign seq_length = result.seq_length;
    assign error      = result.error;

    assign err_clean  = (code_point == '0) && (seq_length == LEN_IDLE);
    assign len_legal  = (seq_length == LEN_ONE) || (seq_length == LEN_TWO) ||
                        (seq_length == LEN_THREE) || (seq_length == LEN_FOUR);
    assign ascii_beat = out_valid && !error && (seq_length == LEN_ONE);

    `ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && error, err_clean)
    `ASSERT_IMP(a_len_ok, clk, rst_n, out_valid && !error, len_legal)
    `ASSERT_IMP(a_ascii_range, clk, rst_n, ascii_beat, code_point[20:7] == '0)
    `ASSERT_IMP(a_backpressure, clk, rst_n, beat.valid && out_valid && out_stall, in_stall)

endmodule
